// ===== hw/rtl/sclm_pkg.sv =====
// ----------------------------------------------------------------------------
// sclm_pkg
// Shared types, constants and the command word table of the command line
// matcher.
// ----------------------------------------------------------------------------
package sclm_pkg;

  // default line capacity (line holds one character less)
  localparam int LINE_CAPACITY_DEF = 16;

  // console control bytes
  localparam logic [7:0] CHAR_BS  = 8'h08;
  localparam logic [7:0] CHAR_DEL = 8'h7F;
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_NUL = 8'h00;

  // result codes outside the word list
  localparam logic [3:0] CODE_UNKNOWN  = 4'd9;
  localparam logic [3:0] CODE_OVERFLOW = 4'd10;

  // command word table
  localparam int WORD_COUNT = 9;
  localparam int WORD_MAX   = 10;

  localparam logic [3:0] WORD_LEN [WORD_COUNT] = '{
    4'd4, 4'd6, 4'd6, 4'd5, 4'd7, 4'd8, 4'd8, 4'd8, 4'd10
  };

  localparam logic [7:0] WORD_TABLE [WORD_COUNT][WORD_MAX] = '{
    '{"p", "i", "n", "g", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"u", "p", "t", "i", "m", "e", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"h", "e", "a", "l", "t", "h", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"f", "a", "u", "l", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"i", "2", "c", "s", "c", "a", "n", 8'h00, 8'h00, 8'h00},
    '{"o", "l", "e", "d", "p", "i", "n", "g", 8'h00, 8'h00},
    '{"o", "l", "e", "d", "t", "e", "s", "t", 8'h00, 8'h00},
    '{"o", "l", "e", "d", "t", "e", "x", "t", 8'h00, 8'h00},
    '{"o", "l", "e", "d", "r", "e", "n", "d", "e", "r"}
  };

  // character of word w at position i, zero past the table width
  function automatic logic [7:0] word_char(input logic [3:0] w, input logic [3:0] i);
    logic [7:0] ch;
    ch = CHAR_NUL;
    if (i < 4'(WORD_MAX)) begin
      ch = WORD_TABLE[w][i];
    end
    return ch;
  endfunction

  // controller to datapath commands
  typedef struct packed {
    logic append;      // store the input byte at the end of the line
    logic erase;       // drop the last character if any
    logic scan_start;  // begin comparing the line from position zero
    logic scan_step;   // compare one character
    logic set_ovf;     // clear the line and stage the overflow code
    logic load_out;    // move the staged code to the output register
  } sclm_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_term;     // input byte ends a line
    logic is_erase;    // input byte erases one character
    logic len_zero;    // line is empty
    logic len_full;    // line holds its full capacity
    logic scan_last;   // current compare step is the final one
  } sclm_status_t;

endpackage

// ===== hw/rtl/sclm_dp.sv =====
// ----------------------------------------------------------------------------
// sclm_dp
// Datapath: line memory, line length, the character compare against all
// command words at once and the result registers.
// ----------------------------------------------------------------------------
module sclm_dp #(
  parameter int LINE_CAPACITY = sclm_pkg::LINE_CAPACITY_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [7:0]              in_rx_byte,
  input  sclm_pkg::sclm_cmd_t     cmd,
  output sclm_pkg::sclm_status_t  status,
  output logic [3:0]              out_result_code
);

  localparam int DEPTH = LINE_CAPACITY - 1;
  localparam int LEN_W = $clog2(LINE_CAPACITY);
  localparam int AW    = $clog2(DEPTH);
  localparam int WC    = sclm_pkg::WORD_COUNT;

  // line memory, entries undefined until written
  logic [7:0]       mem [DEPTH];
  logic [7:0]       q_r;
  logic [AW-1:0]    rd_addr;
  logic [LEN_W-1:0] rd_idx;

  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] idx_r, idx_nxt;
  logic [WC-1:0]    mask_r, mask_nxt;
  logic [3:0]       pend_code_r, pend_code_nxt;
  logic [3:0]       out_code_r;

  logic             char_zero;
  logic             scan_last;
  logic [WC-1:0]    mask_upd;
  logic [WC-1:0]    mask_fin;
  logic [LEN_W-1:0] used_fin;
  logic [3:0]       match_code;

  // byte class and line status
  assign char_zero = (q_r == sclm_pkg::CHAR_NUL);
  assign scan_last = char_zero || ((idx_r + LEN_W'(1)) == len_r);

  assign status.is_term   = (in_rx_byte == sclm_pkg::CHAR_CR) ||
                            (in_rx_byte == sclm_pkg::CHAR_LF);
  assign status.is_erase  = (in_rx_byte == sclm_pkg::CHAR_BS) ||
                            (in_rx_byte == sclm_pkg::CHAR_DEL);
  assign status.len_zero  = (len_r == '0);
  assign status.len_full  = (len_r == LEN_W'(DEPTH));
  assign status.scan_last = scan_last;

  // read address for the next compare step, kept inside the memory
  always_comb begin
    rd_idx = cmd.scan_start ? '0 : (idx_r + LEN_W'(1));
    if (rd_idx >= LEN_W'(DEPTH)) begin
      rd_addr = '0;
    end else begin
      rd_addr = rd_idx[AW-1:0];
    end
  end

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      mem[len_r[AW-1:0]] <= in_rx_byte;
    end
    q_r <= mem[rd_addr];
  end

  // compare current character with every word, then pick the match
  always_comb begin
    for (int w = 0; w < WC; w++) begin
      mask_upd[w] = mask_r[w] &&
                    (idx_r < LEN_W'(sclm_pkg::WORD_LEN[w])) &&
                    (q_r == sclm_pkg::word_char(4'(w), idx_r[3:0]));
    end
    mask_fin   = char_zero ? mask_r : mask_upd;
    used_fin   = char_zero ? idx_r : (idx_r + LEN_W'(1));
    match_code = sclm_pkg::CODE_UNKNOWN;
    for (int w = WC - 1; w >= 0; w--) begin
      if (mask_fin[w] && (used_fin == LEN_W'(sclm_pkg::WORD_LEN[w]))) begin
        match_code = 4'(w);
      end
    end
  end

  // next state of line length, scan position and staged code
  always_comb begin
    len_nxt       = len_r;
    idx_nxt       = idx_r;
    mask_nxt      = mask_r;
    pend_code_nxt = pend_code_r;
    if (cmd.append) begin
      len_nxt = len_r + LEN_W'(1);
    end
    if (cmd.erase && (len_r != '0)) begin
      len_nxt = len_r - LEN_W'(1);
    end
    if (cmd.set_ovf) begin
      len_nxt       = '0;
      pend_code_nxt = sclm_pkg::CODE_OVERFLOW;
    end
    if (cmd.scan_start) begin
      idx_nxt  = '0;
      mask_nxt = '1;
    end
    if (cmd.scan_step) begin
      idx_nxt  = idx_r + LEN_W'(1);
      mask_nxt = mask_upd;
      if (scan_last) begin
        len_nxt       = '0;
        pend_code_nxt = match_code;
      end
    end
  end

  // line length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else begin
      len_r <= len_nxt;
    end
  end

  // scan and result payload registers
  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    mask_r      <= mask_nxt;
    pend_code_r <= pend_code_nxt;
    if (cmd.load_out) begin
      out_code_r <= pend_code_r;
    end
  end

  assign out_result_code = out_code_r;

endmodule

// ===== hw/rtl/sclm_ctrl.sv =====
// ----------------------------------------------------------------------------
// sclm_ctrl
// Controller: takes input beats, runs the line compare and hands results
// to the output register.
// ----------------------------------------------------------------------------
module sclm_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  logic                   out_stall,
  input  sclm_pkg::sclm_status_t status,
  output sclm_pkg::sclm_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  // output register can take a new beat
  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (status.is_term) begin
            if (!status.len_zero) begin
              cmd.scan_start = 1'b1;
              state_nxt      = ST_SCAN;
            end
          end else if (status.is_erase) begin
            cmd.erase = 1'b1;
          end else if (status.len_full) begin
            cmd.set_ovf = 1'b1;
            state_nxt   = ST_WAIT;
          end else begin
            cmd.append = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (slot_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hw/rtl/serial_command_line_matcher_core.sv =====
// ----------------------------------------------------------------------------
// serial_command_line_matcher_core
// Console line editor and command word matcher.
// ----------------------------------------------------------------------------
// Takes one console byte per input beat and keeps a line of up to
// LINE_CAPACITY-1 characters. Backspace or delete drop the last character,
// any other byte except CR and LF is appended, and such a byte at a
// full line clears it and yields the overflow code (10). CR or LF on a
// non-empty line yields the code of the matching command word (0 to 8) or
// unknown (9) and clears the line; the compare ends at the first zero byte
// in the line. Editing bytes leave the input open. A line end is compared
// one character per cycle through the single read port of the line
// memory; after a line end or an overflow the input is stalled until the
// result is in the output register, which also waits while an earlier
// result is still stalled. The line memory needs no clearing after reset.
// ----------------------------------------------------------------------------
module serial_command_line_matcher_core #(
  parameter int LINE_CAPACITY = sclm_pkg::LINE_CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_result_code
);

  sclm_pkg::sclm_cmd_t    cmd;
  sclm_pkg::sclm_status_t status;

  // control
  sclm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // line storage and compare
  sclm_dp #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_rx_byte      (in_rx_byte),
    .cmd             (cmd),
    .status          (status),
    .out_result_code (out_result_code)
  );

endmodule

// ===== hw/rtl/sclm_checker.sv =====
// ----------------------------------------------------------------------------
// sclm_checker
// Port level checks of the command line matcher.
// ----------------------------------------------------------------------------
module sclm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_rx_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] out_result_code
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_result_code)))
    else $error("stalled result beat changed");

  // only defined codes appear
  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_result_code <= sclm_pkg::CODE_OVERFLOW))
    else $error("result code out of range");

  // an erase byte never stalls the following beat
  a_erase_open: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall &&
     ((in_rx_byte == sclm_pkg::CHAR_BS) || (in_rx_byte == sclm_pkg::CHAR_DEL)))
    |=> !in_stall)
    else $error("input stalled after erase byte");

  // a new result follows a stalled input
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without line processing");

endmodule

bind serial_command_line_matcher_core sclm_checker u_sclm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_rx_byte      (in_rx_byte),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_result_code (out_result_code)
);
